>>> rtl/assert_macros.svh
// assertion macros for the checker file rmuv_checker.sv
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// same-cycle implication outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, also checked during reset
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/rmuv_pkg.sv
// shared constants and types of the reflection map uv generator
// no dependencies; imported by every module of the block
`default_nettype none

package rmuv_pkg;

   localparam int COORD_WIDTH_DEF  = 32;
   localparam int NORMAL_WIDTH_DEF = 16;

   localparam int UNIT_SHIFT = 30;          // unit vectors are Q2.30
   localparam int UNIT_W     = 32;          // signed unit component
   localparam int SQ_W       = 62;          // sum of three 30-bit squares
   localparam int LEN_W      = 31;          // floor(sqrt(sum of squares))
   localparam int Q_W        = 32;          // raw quotient of the divider
   localparam int ISQRT_ITER = 31;          // one result bit per stage
   localparam int DIV_STEPS  = 32;          // one quotient bit per stage
   localparam int DOT_W      = 36;          // rounded n.e
   localparam int R_W        = 40;          // reflection components
   localparam int TEX_W      = 16;

   localparam logic [Q_W-1:0]   UNIT_ONE = Q_W'(1) << UNIT_SHIFT;
   localparam logic [TEX_W-1:0] TEX_HALF = 16'h8000;
   localparam logic [TEX_W-1:0] TEX_MAX  = 16'hFFFF;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Z = 2'd2;

   typedef struct packed {
      logic valid;
      logic nonzero;
   } vec_ctl_type;

endpackage

`default_nettype wire

>>> rtl/reflection_map_uv_gen_unit.sv
// top level of the reflection map uv generator: camera registers, eye vector,
// two normalizers around the reflection stage, texture coordinate output
// depends on rmuv_pkg, rmuv_norm, rmuv_reflect
//
// channel   ports                         handshake
// ------    ----------------------------  ---------------------------------
// request   req_pos_*, req_norm_*         start high and busy low at edge
// response  rsp_tex_u, rsp_tex_v, rsp_... rsp_valid high for one cycle
// csr       csr_index, csr_wdata          csr_we high at edge, no wait
//
// one transaction enters every cycle and busy stays low
// each normalizer has 31 square root stages and 32 divider stages, one bit per
//   stage, after its normalizing shift stages (clog2 of the vector width)
// reset is synchronous and clears the valid pipeline and camera registers
// the receiver cannot stall, so results leave in order with fixed latency
`default_nettype none

module reflection_map_uv_gen_unit #(
   parameter int COORD_WIDTH  = rmuv_pkg::COORD_WIDTH_DEF,
   parameter int NORMAL_WIDTH = rmuv_pkg::NORMAL_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_z,
   input  logic signed [NORMAL_WIDTH-1:0]      req_norm_x,
   input  logic signed [NORMAL_WIDTH-1:0]      req_norm_y,
   input  logic signed [NORMAL_WIDTH-1:0]      req_norm_z,
   // response channel
   output logic                                rsp_valid,
   output logic [rmuv_pkg::TEX_W-1:0]          rsp_tex_u,
   output logic [rmuv_pkg::TEX_W-1:0]          rsp_tex_v,
   output logic                                rsp_degenerate,
   // csr write port
   input  logic                                csr_we,
   input  logic [rmuv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [COORD_WIDTH-1:0]              csr_wdata
);
   import rmuv_pkg::*;

   localparam int DW = COORD_WIDTH + 1;

   // the pipeline never holds off a request
   assign busy = 1'b0;

   // camera position registers
   logic signed [COORD_WIDTH-1:0] cam_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < 3; l++) begin
            cam_ff[l] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CAMERA_X: cam_ff[0] <= csr_wdata;
            CSR_CAMERA_Y: cam_ff[1] <= csr_wdata;
            CSR_CAMERA_Z: cam_ff[2] <= csr_wdata;
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // eye vector camera - position, exact in one extra bit
   logic signed [DW-1:0]           d_ff [3];
   logic signed [NORMAL_WIDTH-1:0] n_ff [3];
   logic                           v0_ff;

   always_ff @(posedge clock) begin
      d_ff[0] <= DW'(cam_ff[0]) - DW'(req_pos_x);
      d_ff[1] <= DW'(cam_ff[1]) - DW'(req_pos_y);
      d_ff[2] <= DW'(cam_ff[2]) - DW'(req_pos_z);
      n_ff[0] <= req_norm_x;
      n_ff[1] <= req_norm_y;
      n_ff[2] <= req_norm_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
   end

   // unit eye vector; the normal rides along as side data
   vec_ctl_type                    eye_ctl;
   logic signed [UNIT_W-1:0]       eye_u [3];
   logic [3*NORMAL_WIDTH-1:0]      eye_side;
   logic signed [NORMAL_WIDTH-1:0] eye_n [3];

   rmuv_norm #(
      .VW     (DW),
      .SIDE_W (3 * NORMAL_WIDTH)
   ) u_norm_eye (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v0_ff),
      .in_vec   (d_ff),
      .in_side  ({n_ff[2], n_ff[1], n_ff[0]}),
      .out_ctl  (eye_ctl),
      .out_unit (eye_u),
      .out_side (eye_side)
   );

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         eye_n[l] = eye_side[l*NORMAL_WIDTH +: NORMAL_WIDTH];
      end
   end

   // reflection about the normal
   vec_ctl_type           refl_ctl;
   logic signed [R_W-1:0] refl_r [3];

   rmuv_reflect #(
      .NW (NORMAL_WIDTH)
   ) u_reflect (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (eye_ctl),
      .in_e    (eye_u),
      .in_n    (eye_n),
      .out_ctl (refl_ctl),
      .out_r   (refl_r)
   );

   // unit reflection; the eye nonzero flag rides along
   vec_ctl_type              ru_ctl;
   logic signed [UNIT_W-1:0] ru_u [3];
   logic                     ru_eye_ok;

   rmuv_norm #(
      .VW     (R_W),
      .SIDE_W (1)
   ) u_norm_refl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (refl_ctl.valid),
      .in_vec   (refl_r),
      .in_side  (refl_ctl.nonzero),
      .out_ctl  (ru_ctl),
      .out_unit (ru_u),
      .out_side (ru_eye_ok)
   );

   // (c + 1.0 + rounding) >> 15, saturated
   function automatic logic [TEX_W-1:0] to_tex(input logic signed [UNIT_W-1:0] c);
      logic [UNIT_W:0]    tsum;
      logic [UNIT_W-15:0] tq;
      tsum = (UNIT_W+1)'(c) + (UNIT_W+1)'(UNIT_ONE) + (UNIT_W+1)'(1 << 14);
      tq   = tsum[UNIT_W:15];
      return (tq > (UNIT_W-14)'(TEX_MAX)) ? TEX_MAX : tq[TEX_W-1:0];
   endfunction

   logic ok;
   assign ok = ru_eye_ok && ru_ctl.nonzero;

   logic [TEX_W-1:0] tex_u_ff, tex_v_ff;
   logic             degen_ff, rsp_valid_ff;

   always_ff @(posedge clock) begin
      tex_u_ff <= ok ? to_tex(ru_u[0]) : TEX_HALF;
      tex_v_ff <= ok ? to_tex(ru_u[2]) : TEX_HALF;
      degen_ff <= !ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ru_ctl.valid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tex_u      = tex_u_ff;
   assign rsp_tex_v      = tex_v_ff;
   assign rsp_degenerate = degen_ff;

endmodule

`default_nettype wire

>>> rtl/rmuv_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on rmuv_pkg; used by rmuv_norm
`default_nettype none

module rmuv_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [rmuv_pkg::SQ_W-1:0]  in_sq,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [rmuv_pkg::LEN_W-1:0] out_len,
   output logic [SIDE_W-1:0]          out_side
);
   import rmuv_pkg::*;

   logic [SQ_W-1:0]   x_ff    [ISQRT_ITER];
   logic [SQ_W-1:0]   res_ff  [ISQRT_ITER];
   logic [SIDE_W-1:0] side_ff [ISQRT_ITER];
   logic              v_ff    [ISQRT_ITER];

   for (genvar k = 0; k < ISQRT_ITER; k++) begin : g_step
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      logic [SQ_W-1:0]   x_src, res_src, trial, x_in, res_in;
      logic [SIDE_W-1:0] side_src;
      logic              v_src, ge;

      if (k == 0) begin : g_first
         assign x_src    = in_sq;
         assign res_src  = '0;
         assign side_src = in_side;
         assign v_src    = in_valid;
      end else begin : g_next
         assign x_src    = x_ff[k-1];
         assign res_src  = res_ff[k-1];
         assign side_src = side_ff[k-1];
         assign v_src    = v_ff[k-1];
      end

      always_comb begin
         trial  = res_src + BIT;
         ge     = (x_src >= trial);
         x_in   = ge ? (x_src - trial) : x_src;
         res_in = ge ? ((res_src >> 1) + BIT) : (res_src >> 1);
      end

      always_ff @(posedge clock) begin
         x_ff[k]    <= x_in;
         res_ff[k]  <= res_in;
         side_ff[k] <= side_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_src;
         end
      end
   end

   assign out_valid = v_ff[ISQRT_ITER-1];
   assign out_len   = res_ff[ISQRT_ITER-1][LEN_W-1:0];
   assign out_side  = side_ff[ISQRT_ITER-1];

endmodule

`default_nettype wire

>>> rtl/rmuv_norm.sv
// pipelined normalization of a 3-vector to Q2.30
// depends on rmuv_pkg and rmuv_isqrt
`default_nettype none

module rmuv_norm #(
   parameter int VW     = 33,
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [VW-1:0]               in_vec [3],
   input  logic [SIDE_W-1:0]                  in_side,
   output rmuv_pkg::vec_ctl_type              out_ctl,
   output logic signed [rmuv_pkg::UNIT_W-1:0] out_unit [3],
   output logic [SIDE_W-1:0]                  out_side
);
   import rmuv_pkg::*;

   localparam int W     = (VW > UNIT_SHIFT) ? VW : UNIT_SHIFT;
   localparam int SH_N  = $clog2(W);
   localparam int A_W   = UNIT_SHIFT;
   localparam int TAG_W = SIDE_W + 4;   // {side, nonzero, signs}
   localparam int IS_W  = 3 * A_W + TAG_W;

   // magnitudes and signs
   logic [VW-1:0]     mag_abs [3];
   logic [W-1:0]      mag0_ff [3];
   logic [2:0]        sgn0_ff;
   logic [SIDE_W-1:0] side0_ff;
   logic              v0_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag_abs[l] = in_vec[l][VW-1] ? (~in_vec[l] + 1'b1) : in_vec[l];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         mag0_ff[l] <= W'(mag_abs[l]);
         sgn0_ff[l] <= in_vec[l][VW-1];
      end
      side0_ff <= in_side;
   end

   // largest magnitude
   logic [W-1:0]     mx01, mx_in;
   logic [W-1:0]     mx1_ff;
   logic [W-1:0]     mag1_ff [3];
   logic [TAG_W-1:0] tag1_ff;
   logic             v1_ff;

   always_comb begin
      mx01  = (mag0_ff[0] > mag0_ff[1]) ? mag0_ff[0] : mag0_ff[1];
      mx_in = (mx01 > mag0_ff[2]) ? mx01 : mag0_ff[2];
   end

   always_ff @(posedge clock) begin
      mx1_ff  <= mx_in;
      mag1_ff <= mag0_ff;
      tag1_ff <= {side0_ff, (mx_in != '0), sgn0_ff};
   end

   // left normalize so that the largest magnitude has its msb on top
   logic [W-1:0]     shx_ff   [SH_N];
   logic [W-1:0]     shm_ff   [SH_N][3];
   logic [TAG_W-1:0] shtag_ff [SH_N];
   logic             shv_ff   [SH_N];

   for (genvar i = 0; i < SH_N; i++) begin : g_shift
      localparam int AMT = 1 << (SH_N - 1 - i);
      logic [W-1:0]     mx_src;
      logic [W-1:0]     mg_src [3];
      logic [TAG_W-1:0] tag_src;
      logic             v_src, zt;

      if (i == 0) begin : g_first
         assign mx_src  = mx1_ff;
         assign mg_src  = mag1_ff;
         assign tag_src = tag1_ff;
         assign v_src   = v1_ff;
      end else begin : g_next
         assign mx_src  = shx_ff[i-1];
         assign mg_src  = shm_ff[i-1];
         assign tag_src = shtag_ff[i-1];
         assign v_src   = shv_ff[i-1];
      end

      assign zt = (mx_src[W-1 -: AMT] == '0);

      always_ff @(posedge clock) begin
         shx_ff[i] <= zt ? (mx_src << AMT) : mx_src;
         for (int l = 0; l < 3; l++) begin
            shm_ff[i][l] <= zt ? (mg_src[l] << AMT) : mg_src[l];
         end
         shtag_ff[i] <= tag_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            shv_ff[i] <= 1'b0;
         end else begin
            shv_ff[i] <= v_src;
         end
      end
   end

   // squares, then their sum
   logic [2*A_W-1:0] sq_ff   [3];
   logic [A_W-1:0]   asq_ff  [3];
   logic [TAG_W-1:0] tagsq_ff;
   logic             vsq_ff;
   logic [SQ_W-1:0]  l2_ff;
   logic [A_W-1:0]   asum_ff [3];
   logic [TAG_W-1:0] tagsum_ff;
   logic             vsum_ff;

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         asq_ff[l] <= shm_ff[SH_N-1][l][W-1 -: A_W];
         sq_ff[l]  <= shm_ff[SH_N-1][l][W-1 -: A_W] * shm_ff[SH_N-1][l][W-1 -: A_W];
      end
      tagsq_ff  <= shtag_ff[SH_N-1];
      l2_ff     <= SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
      asum_ff   <= asq_ff;
      tagsum_ff <= tagsq_ff;
   end

   logic [IS_W-1:0]  is_side;
   logic             is_valid;
   logic [LEN_W-1:0] is_len;

   rmuv_isqrt #(
      .SIDE_W (IS_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vsum_ff),
      .in_sq     (l2_ff),
      .in_side   ({tagsum_ff, asum_ff[2], asum_ff[1], asum_ff[0]}),
      .out_valid (is_valid),
      .out_len   (is_len),
      .out_side  (is_side)
   );

   // restoring division a * 2^30 / len, three lanes
   logic [LEN_W-1:0] rem_ff [DIV_STEPS][3];
   logic [Q_W-1:0]   q_ff   [DIV_STEPS][3];
   logic [1:0]       lo_ff  [DIV_STEPS][3];
   logic [LEN_W-1:0] len_ff [DIV_STEPS];
   logic [TAG_W-1:0] dtag_ff[DIV_STEPS];
   logic             dv_ff  [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [LEN_W-1:0] len_src;
      logic [TAG_W-1:0] tag_src;
      logic             v_src;

      if (j == 0) begin : g_first
         assign len_src = is_len;
         assign tag_src = is_side[IS_W-1 -: TAG_W];
         assign v_src   = is_valid;
      end else begin : g_next
         assign len_src = len_ff[j-1];
         assign tag_src = dtag_ff[j-1];
         assign v_src   = dv_ff[j-1];
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [LEN_W-1:0] rem_src;
         logic [Q_W-1:0]   q_src;
         logic [1:0]       lo_src;
         logic             nbit, ge;
         logic [LEN_W:0]   trial;

         if (j == 0) begin : g_first
            assign rem_src = LEN_W'(is_side[l*A_W +: A_W] >> 2);
            assign q_src   = '0;
            assign lo_src  = is_side[l*A_W +: 2];
         end else begin : g_next
            assign rem_src = rem_ff[j-1][l];
            assign q_src   = q_ff[j-1][l];
            assign lo_src  = lo_ff[j-1][l];
         end

         if (j == 0) begin : g_b1
            assign nbit = lo_src[1];
         end else if (j == 1) begin : g_b0
            assign nbit = lo_src[0];
         end else begin : g_bz
            assign nbit = 1'b0;
         end

         always_comb begin
            trial = {rem_src, nbit};
            ge    = (trial >= {1'b0, len_src});
         end

         always_ff @(posedge clock) begin
            rem_ff[j][l] <= ge ? LEN_W'(trial - {1'b0, len_src}) : LEN_W'(trial);
            q_ff[j][l]   <= {q_src[Q_W-2:0], ge};
            lo_ff[j][l]  <= lo_src;
         end
      end

      always_ff @(posedge clock) begin
         len_ff[j]  <= len_src;
         dtag_ff[j] <= tag_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else begin
            dv_ff[j] <= v_src;
         end
      end
   end

   // clamp, restore sign, zero vector gives zero
   logic [Q_W-1:0]           qc     [3];
   logic signed [UNIT_W-1:0] unit_ff [3];
   logic [SIDE_W-1:0]        oside_ff;
   logic                     onz_ff, ov_ff;
   logic [TAG_W-1:0]         ftag;

   assign ftag = dtag_ff[DIV_STEPS-1];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         qc[l] = (q_ff[DIV_STEPS-1][l] > UNIT_ONE) ? UNIT_ONE : q_ff[DIV_STEPS-1][l];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         if (!ftag[3]) begin
            unit_ff[l] <= '0;
         end else if (ftag[l]) begin
            unit_ff[l] <= UNIT_W'(-qc[l]);
         end else begin
            unit_ff[l] <= UNIT_W'(qc[l]);
         end
      end
      oside_ff <= ftag[TAG_W-1:4];
      onz_ff   <= ftag[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         vsq_ff  <= 1'b0;
         vsum_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         v0_ff   <= in_valid;
         v1_ff   <= v0_ff;
         vsq_ff  <= shv_ff[SH_N-1];
         vsum_ff <= vsq_ff;
         ov_ff   <= dv_ff[DIV_STEPS-1];
      end
   end

   assign out_ctl.valid   = ov_ff;
   assign out_ctl.nonzero = onz_ff;
   assign out_unit        = unit_ff;
   assign out_side        = oside_ff;

endmodule

`default_nettype wire

>>> rtl/rmuv_reflect.sv
// reflection r = 2 (n.e) n - e, pipelined over eight stages
// depends on rmuv_pkg; used by the top level
`default_nettype none

module rmuv_reflect #(
   parameter int NW = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rmuv_pkg::vec_ctl_type              in_ctl,
   input  logic signed [rmuv_pkg::UNIT_W-1:0] in_e [3],
   input  logic signed [NW-1:0]               in_n [3],
   output rmuv_pkg::vec_ctl_type              out_ctl,
   output logic signed [rmuv_pkg::R_W-1:0]    out_r [3]
);
   import rmuv_pkg::*;

   localparam int NST = 8;
   localparam int P_W = NW + UNIT_W;
   localparam int S_W = P_W + 2;
   localparam int SH  = NW - 2;
   localparam int T_W = DOT_W + NW;
   localparam int M_W = T_W + 1;
   localparam logic [S_W-1:0] D_HALF = S_W'(1) << (SH - 1);
   localparam logic [M_W-1:0] T_HALF = M_W'(1) << (SH - 1);

   vec_ctl_type              ctl_ff [NST];
   logic signed [UNIT_W-1:0] e_d    [NST-1][3];
   logic signed [NW-1:0]     n_d    [4][3];

   logic signed [P_W-1:0]   p_ff [3];
   logic signed [S_W-1:0]   sum_ff;
   logic [S_W-1:0]          smag_ff;
   logic                    sneg_ff;
   logic signed [DOT_W-1:0] dot_ff;
   logic signed [T_W-1:0]   t_ff [3];
   logic [M_W-1:0]          tmag_ff [3];
   logic [2:0]              tneg_ff;
   logic signed [R_W-1:0]   s_ff [3];
   logic signed [R_W-1:0]   r_ff [3];

   logic [S_W-1:0] dr;
   logic [T_W-1:0] ta [3];
   logic [M_W-1:0] sr [3];

   always_comb begin
      dr = (smag_ff + D_HALF) >> SH;
      for (int l = 0; l < 3; l++) begin
         ta[l] = t_ff[l][T_W-1] ? T_W'(-t_ff[l]) : T_W'(t_ff[l]);
         sr[l] = (tmag_ff[l] + T_HALF) >> SH;
      end
   end

   always_ff @(posedge clock) begin
      e_d[0] <= in_e;
      for (int k = 1; k < NST - 1; k++) begin
         e_d[k] <= e_d[k-1];
      end
      n_d[0] <= in_n;
      for (int k = 1; k < 4; k++) begin
         n_d[k] <= n_d[k-1];
      end

      // products and their sum
      for (int l = 0; l < 3; l++) begin
         p_ff[l] <= in_n[l] * in_e[l];
      end
      sum_ff <= S_W'(p_ff[0]) + S_W'(p_ff[1]) + S_W'(p_ff[2]);

      // round n.e to Q.30, half away from zero
      smag_ff <= sum_ff[S_W-1] ? S_W'(-sum_ff) : S_W'(sum_ff);
      sneg_ff <= sum_ff[S_W-1];
      dot_ff  <= sneg_ff ? DOT_W'(-DOT_W'(dr)) : DOT_W'(dr);

      for (int l = 0; l < 3; l++) begin
         t_ff[l]    <= dot_ff * n_d[3][l];
         tmag_ff[l] <= {ta[l], 1'b0};      // doubled
         tneg_ff[l] <= t_ff[l][T_W-1];
         s_ff[l]    <= tneg_ff[l] ? R_W'(-R_W'(sr[l])) : R_W'(sr[l]);
         r_ff[l]    <= s_ff[l] - R_W'(e_d[NST-2][l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int k = 1; k < NST; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   assign out_ctl = ctl_ff[NST-1];
   assign out_r   = r_ff;

endmodule

`default_nettype wire

>>> rtl/rmuv_checker.sv
// port-level checks of the reflection map uv generator, bound to the top level
// depends on rmuv_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module rmuv_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [rmuv_pkg::TEX_W-1:0] rsp_tex_u,
   input logic [rmuv_pkg::TEX_W-1:0] rsp_tex_v,
   input logic                       rsp_degenerate
);
   import rmuv_pkg::*;

   logic degen_rsp;
   logic tex_center;
   assign degen_rsp  = rsp_valid && rsp_degenerate;
   assign tex_center = (rsp_tex_u == TEX_HALF) && (rsp_tex_v == TEX_HALF);

   // pipeline takes a transaction every cycle
   `ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)
   // degenerate vectors map to the center of the texture
   `ASSERT_IMPLY(a_degen_center, clock, reset, degen_rsp, tex_center)
   // reset flushes everything in flight
   `ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)

endmodule

bind reflection_map_uv_gen_unit rmuv_checker u_rmuv_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_tex_u      (rsp_tex_u),
   .rsp_tex_v      (rsp_tex_v),
   .rsp_degenerate (rsp_degenerate)
);

`default_nettype wire
